>>> rtl/mha_pkg.sv
// shared types and constants for the motion history accumulator
// frame geometry, register indexes, configuration and memory entry layout
// no dependencies
package mha_pkg;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;
    localparam int PIXEL_COUNT  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int MEM_ADDR_W   = $clog2(PIXEL_COUNT);

    localparam int DEPTH_W = 8;
    localparam int INDEX_W = 19;
    localparam int HIST_W  = 8;
    localparam int ACC_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int S_TDATA_W = ((DEPTH_W + INDEX_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ACC_W + HIST_W + 7) / 8) * 8;

    localparam logic [HIST_W-1:0] RESET_MOTION_VALUE    = 8'd15;
    localparam logic [HIST_W-1:0] RESET_DECAY_STEP      = 8'd15;
    localparam logic [HIST_W-1:0] RESET_INITIAL_HISTORY = 8'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOTION_VALUE    = 2'd0,
        CFG_DECAY_STEP      = 2'd1,
        CFG_INITIAL_HISTORY = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [HIST_W-1:0] motion_value;
        logic [HIST_W-1:0] decay_step;
        logic [HIST_W-1:0] initial_history;
    } cfg_t;

    typedef struct packed {
        logic              occupied;
        logic [HIST_W-1:0] history;
        logic [ACC_W-1:0]  acc;
    } entry_t;

endpackage

>>> rtl/motion_history_accumulator.sv
// motion history accumulator top level: config registers, pixel memory, pipeline
// depends on mha_pkg and mha_update
//
// One pixel request per clock, sustained while the output is not held by
// m_tready. A request reads its pixel's entry (occupancy, history,
// accumulator) from one single-port-per-direction memory into a read
// register; the update stage updates it, writes it back and places the
// result in the output register. A request for the same pixel right behind the
// previous one takes the just-written entry by forwarding. A pixel index at or
// beyond the frame size changes nothing and returns all-zero fields. Entries
// hold garbage until the pixel has seen a clip start. Configuration is taken
// at any time and should be written while no request is in flight.
module motion_history_accumulator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mha_pkg::S_TDATA_W-1:0]     s_tdata,  // depth_sample, pixel_index, zeros
    input  logic                              s_tuser,  // clip_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mha_pkg::M_TDATA_W-1:0]     m_tdata,  // accumulated_history, history_value
    output logic                              m_tuser,  // motion_seen
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mha_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mha_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mha_pkg::*;

    cfg_t cfg_reg;

    entry_t mem [PIXEL_COUNT];
    entry_t rd_data_reg;

    logic                  st_valid_reg;
    logic                  st_in_range_reg;
    logic [MEM_ADDR_W-1:0] st_addr_reg;
    logic [DEPTH_W-1:0]    st_depth_reg;
    logic                  st_start_reg;

    logic                  fw_valid_reg;
    logic [MEM_ADDR_W-1:0] fw_addr_reg;
    entry_t                fw_data_reg;

    logic                  m_tvalid_reg;
    logic [ACC_W-1:0]      out_acc_reg;
    logic [HIST_W-1:0]     out_hist_reg;
    logic                  out_seen_reg;

    logic [DEPTH_W-1:0]    s_depth;
    logic [INDEX_W-1:0]    s_index;
    logic                  s_in_range;
    logic [MEM_ADDR_W-1:0] s_addr;
    logic                  s_accept;
    logic                  st_advance;
    entry_t                old_entry;
    entry_t                new_entry;
    logic                  motion_seen;

    assign s_depth    = s_tdata[DEPTH_W-1:0];
    assign s_index    = s_tdata[DEPTH_W+INDEX_W-1:DEPTH_W];
    assign s_in_range = (32'(s_index) < 32'(PIXEL_COUNT));
    assign s_addr     = MEM_ADDR_W'(s_index);

    assign st_advance = !m_tvalid_reg || m_tready;
    assign s_tready   = !st_valid_reg || st_advance;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.motion_value    <= RESET_MOTION_VALUE;
            cfg_reg.decay_step      <= RESET_DECAY_STEP;
            cfg_reg.initial_history <= RESET_INITIAL_HISTORY;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MOTION_VALUE:    cfg_reg.motion_value    <= cfg_data;
                CFG_DECAY_STEP:      cfg_reg.decay_step      <= cfg_data;
                CFG_INITIAL_HISTORY: cfg_reg.initial_history <= cfg_data;
                default: ;
            endcase
        end
    end

    // pixel memory
    always_ff @(posedge aclk) begin
        if (st_valid_reg && st_advance && st_in_range_reg) begin
            mem[st_addr_reg] <= new_entry;
        end
        if (s_accept && s_in_range) begin
            rd_data_reg <= mem[s_addr];
        end
    end

    assign old_entry = (fw_valid_reg && fw_addr_reg == st_addr_reg) ? fw_data_reg : rd_data_reg;

    mha_update u_update (
        .old_entry    (old_entry),
        .depth_sample (st_depth_reg),
        .clip_start   (st_start_reg),
        .cfg          (cfg_reg),
        .new_entry    (new_entry),
        .motion_seen  (motion_seen)
    );

    // update stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_accept) begin
            st_valid_reg <= 1'b1;
        end else if (st_advance) begin
            st_valid_reg <= 1'b0;
        end
        if (s_accept) begin
            st_in_range_reg <= s_in_range;
            st_addr_reg     <= s_addr;
            st_depth_reg    <= s_depth;
            st_start_reg    <= s_tuser;
        end
    end

    // last write, for back-to-back requests to one pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_valid_reg <= 1'b0;
        end else if (st_valid_reg && st_advance && st_in_range_reg) begin
            fw_valid_reg <= 1'b1;
        end
        if (st_valid_reg && st_advance && st_in_range_reg) begin
            fw_addr_reg <= st_addr_reg;
            fw_data_reg <= new_entry;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (st_advance) begin
            m_tvalid_reg <= st_valid_reg;
        end
        if (st_advance && st_valid_reg) begin
            if (st_in_range_reg) begin
                out_acc_reg  <= new_entry.acc;
                out_hist_reg <= new_entry.history;
                out_seen_reg <= motion_seen;
            end else begin
                out_acc_reg  <= '0;
                out_hist_reg <= '0;
                out_seen_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({out_hist_reg, out_acc_reg});
    assign m_tuser  = out_seen_reg;

endmodule

>>> rtl/mha_update.sv
// per-pixel history update: binarize, edge detect, load or decay, accumulate
// depends on mha_pkg
module mha_update (
    input  mha_pkg::entry_t              old_entry,
    input  logic [mha_pkg::DEPTH_W-1:0]  depth_sample,
    input  logic                         clip_start,
    input  mha_pkg::cfg_t                cfg,
    output mha_pkg::entry_t              new_entry,
    output logic                         motion_seen
);
    import mha_pkg::*;

    logic              occ;
    logic [HIST_W-1:0] decayed;

    assign occ = (depth_sample != '0);
    assign decayed = (old_entry.history > cfg.decay_step)
                   ? old_entry.history - cfg.decay_step : '0;

    always_comb begin
        new_entry.occupied = occ;
        if (clip_start) begin
            motion_seen       = 1'b0;
            new_entry.history = cfg.initial_history;
            new_entry.acc     = '0;
        end else begin
            motion_seen       = occ && !old_entry.occupied;
            new_entry.history = motion_seen ? cfg.motion_value : decayed;
            new_entry.acc     = old_entry.acc + ACC_W'(new_entry.history);
        end
    end

endmodule
